// ----- rtl/core/nnpi_pkg.sv -----
// Shared constants and types for the nonnegative projected iteration block.
package nnpi_pkg;

  localparam int MAX_SIZE  = 64;
  localparam int SIZE_CAP  = (MAX_SIZE < 64) ? MAX_SIZE : 64;
  localparam int IDX_W     = 6;
  localparam int N_W       = 7;
  localparam int MAT_AW    = 2 * IDX_W;
  localparam int MAT_DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int SOL_AW    = IDX_W + 1;
  localparam int DATA_W    = 32;
  localparam int LEVEL_W   = 17;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;

  localparam logic [1:0] OP_LOAD_MAT = 2'd0;
  localparam logic [1:0] OP_LOAD_OFF = 2'd1;
  localparam logic [1:0] OP_START    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER = 1'd1;

  localparam logic [N_W-1:0]  SIZE_RESET = 7'd64;
  localparam logic [15:0]     ITER_RESET = 16'd1000;

  typedef struct packed {
    logic              go;
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] den;
  } div_req_t;

endpackage

// ----- rtl/core/nonnegative_projected_iteration.sv -----
// Top level of the nonnegative projected iteration block.
// A load beat (matrix or offset entry) leaves busy low. A start beat holds busy high
// while one shared multiply-accumulate unit, fed by the single read port of the matrix
// memory, walks every row once per iteration for the configured iteration count; then
// the block finds the largest entry and forms each level with the serial divider (each
// level is zero, without the divider, when the largest entry is zero). The results come
// out as n beats, where n is the size in use, one per out_valid pulse, in index order
// with out_last on the final one; they cannot be held off, so the receiver must take
// each beat in the cycle it is shown.
module nonnegative_projected_iteration import nnpi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_op,
  input  logic [IDX_W-1:0]      in_row,
  input  logic [IDX_W-1:0]      in_col,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                  out_valid,
  output logic [IDX_W-1:0]      out_index,
  output logic [LEVEL_W-1:0]    out_level,
  output logic                  out_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROW   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_MAX   = 3'd3;
  localparam logic [2:0] S_MAXW  = 3'd4;
  localparam logic [2:0] S_ORD   = 3'd5;
  localparam logic [2:0] S_ODIV  = 3'd6;
  localparam logic [2:0] S_OWAIT = 3'd7;

  logic [2:0]         state_r, state_nxt;
  logic [N_W-1:0]     size_r;
  logic [15:0]        iter_cfg_r;
  logic [N_W-1:0]     n_r;
  logic [N_W-1:0]     n_sel;
  logic [15:0]        iter_left_r;
  logic [IDX_W-1:0]   i_r;
  logic [N_W-1:0]     j_r;
  logic               bank_r;
  logic               zero_r;
  logic               rd_v_r;
  logic               pv_r;
  logic               mx_v_r;
  logic signed [63:0] acc_r;
  logic signed [63:0] prod_r;
  logic [DATA_W-1:0]  top_r;

  logic               accept;
  logic               row_end;
  logic               last_row;

  logic [DATA_W-1:0]  mat_mem [MAT_DEPTH];
  logic [DATA_W-1:0]  mat_q_r;
  logic [DATA_W-1:0]  off_mem [MAX_SIZE];
  logic [DATA_W-1:0]  off_q_r;
  logic [DATA_W-1:0]  sol_mem [2 * MAX_SIZE];
  logic [DATA_W-1:0]  sol_q_r;
  logic [SOL_AW-1:0]  sol_ra;
  logic               sol_we;
  logic [DATA_W-1:0]  sol_op;

  logic signed [64:0] acc_sum;
  logic signed [63:0] acc_sat;
  logic signed [48:0] wb_sum;
  logic [DATA_W-1:0]  wb_val;

  div_req_t             div_req;
  logic                 div_done;
  logic [LEVEL_W-1:0]   div_quot;

  logic                 out_valid_r;
  logic [IDX_W-1:0]     out_index_r;
  logic [LEVEL_W-1:0]   out_level_r;
  logic                 out_last_r;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign row_end  = (j_r == n_r - N_W'(1));
  assign last_row = ({1'b0, i_r} == n_r - N_W'(1));

  always_comb begin
    n_sel = size_r;
    if (size_r > N_W'(SIZE_CAP)) begin
      n_sel = N_W'(SIZE_CAP);
    end
    if (size_r < N_W'(2)) begin
      n_sel = N_W'(2);
    end
  end

  // Stored entries: the matrix and offsets are written by load beats.
  always_ff @(posedge clk) begin
    if (accept && in_op == OP_LOAD_MAT) begin
      mat_mem[{in_row, in_col}] <= in_value;
    end
    mat_q_r <= mat_mem[{i_r, j_r[IDX_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (accept && in_op == OP_LOAD_OFF) begin
      off_mem[in_row] <= in_value;
    end
    off_q_r <= off_mem[i_r];
  end

  // Two banks of the solution: the old one is read while the new one is written.
  assign sol_ra = (state_r == S_ROW || state_r == S_MAX) ?
                  {bank_r, j_r[IDX_W-1:0]} : {bank_r, i_r};
  assign sol_we = (state_r == S_DRAIN) && !rd_v_r && !pv_r;

  always_ff @(posedge clk) begin
    if (sol_we) begin
      sol_mem[{~bank_r, i_r}] <= wb_val;
    end
    sol_q_r <= sol_mem[sol_ra];
  end

  // The first iteration after start sees an all-zero old solution.
  assign sol_op = zero_r ? '0 : sol_q_r;

  assign acc_sum = {acc_r[63], acc_r} + {prod_r[63], prod_r};
  always_comb begin
    acc_sat = acc_sum[63:0];
    if (acc_sum[64] != acc_sum[63]) begin
      acc_sat = acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
  end

  // Floor division by 65536 is the arithmetic shift; then add offset and clamp.
  assign wb_sum = {acc_r[63], acc_r[63:16]} + {{17{off_q_r[DATA_W-1]}}, off_q_r};
  always_comb begin
    if (wb_sum[48]) begin
      wb_val = '0;
    end else if (wb_sum[47:31] != '0) begin
      wb_val = {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      wb_val = wb_sum[DATA_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_op == OP_START) begin
          state_nxt = (iter_cfg_r == '0) ? S_MAX : S_ROW;
        end
      end
      S_ROW: begin
        if (row_end) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sol_we) begin
          if (last_row && iter_left_r == 16'd1) begin
            state_nxt = S_MAX;
          end else begin
            state_nxt = S_ROW;
          end
        end
      end
      S_MAX: begin
        if (row_end) begin
          state_nxt = S_MAXW;
        end
      end
      S_MAXW: begin
        state_nxt = S_ORD;
      end
      S_ORD: begin
        state_nxt = S_ODIV;
      end
      S_ODIV: begin
        if (top_r == '0) begin
          state_nxt = last_row ? S_IDLE : S_ORD;
        end else begin
          state_nxt = S_OWAIT;
        end
      end
      S_OWAIT: begin
        if (div_done) begin
          state_nxt = last_row ? S_IDLE : S_ORD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= SIZE_RESET;
      iter_cfg_r  <= ITER_RESET;
      bank_r      <= 1'b0;
      rd_v_r      <= 1'b0;
      pv_r        <= 1'b0;
      mx_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_v_r      <= (state_r == S_ROW);
      pv_r        <= rd_v_r;
      mx_v_r      <= (state_r == S_MAX);
      out_valid_r <= ((state_r == S_ODIV) && (top_r == '0)) ||
                     ((state_r == S_OWAIT) && div_done);

      if (cfg_we) begin
        case (cfg_index)
          CFG_SIZE: size_r     <= cfg_data[N_W-1:0];
          CFG_ITER: iter_cfg_r <= cfg_data;
          default:  ;
        endcase
      end

      if (rd_v_r) begin
        prod_r <= $signed(mat_q_r) * $signed(sol_op);
      end
      if (pv_r) begin
        acc_r <= acc_sat;
      end
      if (mx_v_r && ($signed(sol_op) > $signed(top_r))) begin
        top_r <= sol_op;
      end

      case (state_r)
        S_IDLE: begin
          if (accept && in_op == OP_START) begin
            n_r         <= n_sel;
            iter_left_r <= iter_cfg_r;
            i_r         <= '0;
            j_r         <= '0;
            zero_r      <= 1'b1;
            acc_r       <= '0;
            top_r       <= '0;
          end
        end
        S_ROW: begin
          j_r <= j_r + N_W'(1);
        end
        S_DRAIN: begin
          if (sol_we) begin
            acc_r <= '0;
            j_r   <= '0;
            if (last_row) begin
              i_r         <= '0;
              bank_r      <= ~bank_r;
              zero_r      <= 1'b0;
              iter_left_r <= iter_left_r - 16'd1;
            end else begin
              i_r <= i_r + IDX_W'(1);
            end
          end
        end
        S_MAX: begin
          j_r <= j_r + N_W'(1);
        end
        S_ODIV: begin
          if (top_r == '0) begin
            out_index_r <= i_r;
            out_level_r <= '0;
            out_last_r  <= last_row;
            i_r         <= i_r + IDX_W'(1);
          end
        end
        S_OWAIT: begin
          if (div_done) begin
            out_index_r <= i_r;
            out_level_r <= div_quot;
            out_last_r  <= last_row;
            i_r         <= i_r + IDX_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign div_req.go  = (state_r == S_ODIV) && (top_r != '0);
  assign div_req.num = sol_op;
  assign div_req.den = top_r;

  nnpi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_level = out_level_r;
  assign out_last  = out_last_r;

endmodule

// ----- rtl/core/nnpi_div.sv -----
// Bit-serial divider producing the 17-bit level quotient of num * 65536 / den.
module nnpi_div import nnpi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  div_req_t           req,
  output logic               done,
  output logic [LEVEL_W-1:0] quot
);

  logic               busy_r;
  logic [4:0]         cnt_r;
  logic [DATA_W-1:0]  rem_r;
  logic [DATA_W-1:0]  den_r;
  logic               nb_r;
  logic [LEVEL_W-1:0] q_r;
  logic               done_r;
  logic [DATA_W:0]    trial;
  logic               fits;

  assign trial = {rem_r, nb_r};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !req.go && busy_r && (cnt_r == 5'd1);
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(LEVEL_W);
        rem_r  <= {1'b0, req.num[DATA_W-1:1]};
        nb_r   <= req.num[0];
        den_r  <= req.den;
        q_r    <= '0;
      end else if (busy_r) begin
        rem_r <= fits ? DATA_W'(trial - {1'b0, den_r}) : trial[DATA_W-1:0];
        nb_r  <= 1'b0;
        q_r   <= {q_r[LEVEL_W-2:0], fits};
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ----- verif/nnpi_checker.sv -----
// Checker that predicts and compares the result beats of the nonnegative projected iteration block.
module nnpi_checker import nnpi_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic [1:0]               in_op,
  input  logic [IDX_W-1:0]         in_row,
  input  logic [IDX_W-1:0]         in_col,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     out_valid,
  input  logic [IDX_W-1:0]         out_index,
  input  logic [LEVEL_W-1:0]       out_level,
  input  logic                     out_last,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  output int                       errors,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IDX_W-1:0]   index;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } level_beat_t;

  logic signed [DATA_W-1:0] coef [MAX_SIZE][MAX_SIZE];
  logic signed [DATA_W-1:0] bias [MAX_SIZE];
  logic signed [DATA_W-1:0] sol_prev [MAX_SIZE];
  logic signed [DATA_W-1:0] sol_next [MAX_SIZE];
  logic [N_W-1:0]           size_reg;
  logic [15:0]              iter_reg;
  level_beat_t              level_queue [$];

  task automatic report_mismatch(string what);
    errors++;
    $display("%0t ns: mismatch: %s", $realtime, what);
  endtask

  // Runs the clamped iteration from a cleared solution and queues one level beat per entry.
  task automatic predict_levels();
    int                 n;
    logic signed [63:0] acc, prod, lhs, rhs, sum;
    logic [64:0]        wide;
    logic [DATA_W-1:0]  peak;
    logic [47:0]        ratio;
    level_beat_t        beat;
    n = (size_reg > SIZE_CAP) ? SIZE_CAP : (size_reg < 2) ? 2 : int'(size_reg);
    for (int i = 0; i < n; i++) sol_prev[i] = '0;
    for (int k = 0; k < int'(iter_reg); k++) begin
      for (int i = 0; i < n; i++) begin
        acc = '0;
        for (int j = 0; j < n; j++) begin
          lhs = coef[i][j];
          rhs = sol_prev[j];
          prod = lhs * rhs;
          wide = {acc[63], acc} + {prod[63], prod};
          if (wide[64] != wide[63]) begin
            acc = wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
          end else begin
            acc = wide[63:0];
          end
        end
        rhs = bias[i];
        sum = (acc >>> 16) + rhs;
        if (sum > 64'sh7FFF_FFFF) sum = 64'sh7FFF_FFFF;
        if (sum < 0) sum = 0;
        sol_next[i] = sum[DATA_W-1:0];
      end
      for (int i = 0; i < n; i++) sol_prev[i] = sol_next[i];
    end
    peak = '0;
    for (int i = 0; i < n; i++) begin
      if (sol_prev[i] > $signed(peak)) peak = sol_prev[i];
    end
    for (int i = 0; i < n; i++) begin
      ratio = (peak == 0) ? '0 : {sol_prev[i], 16'h0} / {16'h0, peak};
      beat = level_beat_t'{index: IDX_W'(i), level: ratio[LEVEL_W-1:0],
                           last: (i == n - 1)};
      level_queue.insert(level_queue.size(), beat);
    end
  endtask

  always @(posedge clk) begin
    level_beat_t want;
    if (!rst_n) begin
      size_reg = SIZE_RESET;
      iter_reg = ITER_RESET;
      level_queue.delete();
    end else begin
      if (out_valid) begin
        if (level_queue.size() == 0) begin
          report_mismatch($sformatf("result beat index %0d with nothing expected", out_index));
        end else begin
          want = level_queue.pop_front();
          if (out_index !== want.index)
            report_mismatch($sformatf("index %0d, expected %0d", out_index, want.index));
          if (out_level !== want.level)
            report_mismatch($sformatf("level %0d at index %0d, expected %0d",
                                      out_level, want.index, want.level));
          if (out_last !== want.last)
            report_mismatch($sformatf("last %0b at index %0d, expected %0b",
                                      out_last, want.index, want.last));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SIZE: size_reg = cfg_data[N_W-1:0];
          CFG_ITER: iter_reg = cfg_data[15:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (in_op)
          OP_LOAD_MAT: coef[in_row][in_col] = in_value;
          OP_LOAD_OFF: bias[in_row] = in_value;
          OP_START:    predict_levels();
          default: ;
        endcase
      end
    end
    pending = level_queue.size();
  end

endmodule

// ----- verif/nonnegative_projected_iteration_test.sv -----
// Testbench top for the nonnegative projected iteration block: stimulus, watchdog and verdict.
module nonnegative_projected_iteration_test;
  timeunit 1ns;
  timeprecision 1ps;
  import nnpi_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         QUIET_LIMIT  = 3_000_000;
  localparam int         RANDOM_BEATS = 280;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [1:0]               in_op;
  logic [IDX_W-1:0]         in_row;
  logic [IDX_W-1:0]         in_col;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic [IDX_W-1:0]         out_index;
  logic [LEVEL_W-1:0]       out_level;
  logic                     out_last;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_W-1:0]         cfg_data;
  int                       errors;
  int                       pending;

  int burst_left;
  int beats_sent;
  int active_n;
  int quiet_cycles;
  bit mat_written [MAX_SIZE][MAX_SIZE];
  bit off_written [MAX_SIZE];

  nonnegative_projected_iteration u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_op     (in_op),
    .in_row    (in_row),
    .in_col    (in_col),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_index (out_index),
    .out_level (out_level),
    .out_last  (out_last),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  nnpi_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_op     (in_op),
    .in_row    (in_row),
    .in_col    (in_col),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_index (out_index),
    .out_level (out_level),
    .out_last  (out_last),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #5ns clk = 1'b1;
    #5ns clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [DATA_W-1:0] extreme_value();
    case ($urandom_range(0, 3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      default: return 32'h0000_0000;
    endcase
  endfunction

  // Mostly small coefficients so that the iteration tends to settle instead of saturating.
  function automatic logic [DATA_W-1:0] coef_value();
    int unsigned pick, span;
    pick = $urandom_range(0, 19);
    span = 32768 / active_n;
    if (pick < 14) return $urandom_range(0, 2 * span) - span;
    if (pick < 17) return $urandom;
    return extreme_value();
  endfunction

  function automatic logic [DATA_W-1:0] bias_value();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) return $urandom_range(0, 32'h6_0000) - 32'h2_0000;
    if (pick < 17) return $urandom;
    return extreme_value();
  endfunction

  task automatic go_quiet();
    @(negedge clk);
    start = 1'b0;
    in_op = 2'($urandom);
    in_row = IDX_W'($urandom);
    in_col = IDX_W'($urandom);
    in_value = $urandom;
    burst_left = 0;
  endtask

  task automatic drive_beat(logic [1:0] op, int row, int col, logic [DATA_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 :
            ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
      if (gap > 0) begin
        go_quiet();
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk);
    start = 1'b1;
    in_op = op;
    in_row = IDX_W'(row);
    in_col = IDX_W'(col);
    in_value = value;
    do @(posedge clk); while (busy);
    burst_left--;
    if (op == OP_LOAD_MAT) mat_written[row][col] = 1'b1;
    if (op == OP_LOAD_OFF) off_written[row] = 1'b1;
    if (op != OP_UNUSED) beats_sent++;
  endtask

  task automatic wait_drained();
    go_quiet();
    while (pending != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    wait_drained();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_index = CFG_IDX_W'($urandom);
    cfg_data = CFG_W'($urandom);
  endtask

  task automatic configure(int size, int iters);
    logic [CFG_W-1:0] data;
    data = CFG_W'($urandom);
    data[N_W-1:0] = N_W'(size);
    active_n = (size > SIZE_CAP) ? SIZE_CAP : (size < 2) ? 2 : size;
    write_reg(CFG_SIZE, data);
    write_reg(CFG_ITER, CFG_W'(iters));
  endtask

  // Every entry a solve reads must have been loaded at least once.
  task automatic fill_active();
    for (int i = 0; i < active_n; i++) begin
      if (!off_written[i]) drive_beat(OP_LOAD_OFF, i, $urandom_range(0, 63), bias_value());
      for (int j = 0; j < active_n; j++) begin
        if (!mat_written[i][j]) drive_beat(OP_LOAD_MAT, i, j, coef_value());
      end
    end
  endtask

  initial begin
    int pick, size, iters;
    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_LOAD_MAT;
    in_row = '0;
    in_col = '0;
    in_value = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_SIZE;
    cfg_data = '0;
    burst_left = 0;
    beats_sent = 0;
    active_n = SIZE_CAP;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    configure(2, 0);
    drive_beat(OP_LOAD_MAT, 0, 0, 32'h7FFF_FFFF);
    drive_beat(OP_LOAD_MAT, 0, 1, 32'h8000_0000);
    drive_beat(OP_LOAD_MAT, 1, 0, 32'hFFFF_FFFF);
    drive_beat(OP_LOAD_MAT, 1, 1, 32'h0000_0000);
    drive_beat(OP_LOAD_OFF, 0, 0, 32'h7FFF_FFFF);
    drive_beat(OP_LOAD_OFF, 1, 63, 32'h8000_0000);
    drive_beat(OP_START, 63, 63, 32'hFFFF_FFFF);
    drive_beat(OP_UNUSED, 63, 0, 32'h0000_0000);
    write_reg(CFG_ITER, 16'd1);
    drive_beat(OP_START, 0, 0, 32'h0000_0000);
    write_reg(CFG_ITER, 16'd2);
    drive_beat(OP_START, 21, 42, 32'h5555_AAAA);
    configure(1, 1);
    drive_beat(OP_LOAD_OFF, 0, 0, 32'hFFFB_0000);
    drive_beat(OP_START, 0, 0, 32'h0000_0000);
    configure(3, 2);
    for (int j = 0; j < 3; j++) begin
      drive_beat(OP_LOAD_MAT, 0, j, 32'h7FFF_FFFF);
      drive_beat(OP_LOAD_MAT, 1, j, 32'h8000_0000);
      drive_beat(OP_LOAD_OFF, j, j, 32'h7FFF_FFFF);
    end
    drive_beat(OP_LOAD_MAT, 2, 0, 32'h0000_0001);
    drive_beat(OP_LOAD_MAT, 2, 1, 32'hFFFF_FFFF);
    drive_beat(OP_LOAD_MAT, 2, 2, 32'h0001_0000);
    drive_beat(OP_START, 0, 0, 32'h0000_0000);

    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      pick = $urandom_range(0, 19);
      size = (pick == 0) ? $urandom_range(0, 1) :
             (pick < 3) ? $urandom_range(6, 8) : $urandom_range(2, 5);
      pick = $urandom_range(0, 19);
      iters = (pick < 2) ? 0 : (pick < 16) ? $urandom_range(1, 12) : $urandom_range(13, 80);
      configure(size, iters);
      fill_active();
      repeat ($urandom_range(1, 4)) begin
        repeat ($urandom_range(0, 6)) begin
          pick = $urandom_range(0, 19);
          if (pick < 2) begin
            drive_beat(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
          end else if (pick < 5) begin
            drive_beat(pick[0] ? OP_LOAD_OFF : OP_LOAD_MAT, $urandom_range(0, MAX_SIZE - 1),
                       $urandom_range(0, MAX_SIZE - 1), coef_value());
          end else if (pick < 12) begin
            drive_beat(OP_LOAD_MAT, $urandom_range(0, active_n - 1),
                       $urandom_range(0, active_n - 1), coef_value());
          end else begin
            drive_beat(OP_LOAD_OFF, $urandom_range(0, active_n - 1), $urandom_range(0, 63),
                       bias_value());
          end
        end
        if ($urandom_range(0, 7) == 0) wait_drained();
        drive_beat(OP_START, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
      end
    end

    configure(64, 2);
    fill_active();
    drive_beat(OP_START, 0, 0, $urandom);
    configure(127, 1);
    drive_beat(OP_START, 63, 63, $urandom);
    configure(0, 16'hFFFF);
    drive_beat(OP_START, 0, 63, $urandom);

    wait_drained();
    repeat (50) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
